/* rtl/core/ctsq_pkg.sv */
package ctsq_pkg;

  localparam int READY_DEPTH  = 16;
  localparam int DELAY_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;
  localparam int TICK_BITS    = 16;
  localparam int PRIO_W       = 4;
  localparam int EXP_W        = 5;

  localparam int RA_W = $clog2(READY_DEPTH);
  localparam int RC_W = $clog2(READY_DEPTH + 1);
  localparam int DA_W = $clog2(DELAY_DEPTH);
  localparam int DC_W = $clog2(DELAY_DEPTH + 1);

  localparam int READY_W = TASK_ID_BITS + PRIO_W;
  localparam int DELAY_W = TASK_ID_BITS + TICK_BITS;

  localparam logic [PRIO_W-1:0] LOWEST_RESET = PRIO_W'(8);

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_RERUN    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_DROPPED    = 2'd3
  } status_t;

endpackage

/* rtl/core/cooperative_task_scheduler_queues_core.sv */
// Task scheduler with a priority-sorted ready queue and a tick-sorted delay queue.
// Input: pulse start with in_req_type and its operands while busy is low; the
// item is taken at that edge and busy stays high through the result cycle.
// Requests: add (in_task_id, in_priority_req clamped to 0..lowest), dispatch
// (pop the ready head), tick (in_amount elapsed ticks), rerun of the current
// task (in_amount delay, zero requeues it as ready).
// Result: out_valid is high for exactly one cycle with out_status, out_task_id
// and out_expired_count; the receiver cannot stall, so nothing waits.
// Storage: both queues live in RAMs with one read port and a registered read;
// each step of an insertion or shift takes a read and a write. A tick reads
// the delay entries in order, inserts each expired one into the ready queue,
// then shifts the remaining entries down with the elapsed ticks subtracted.
// Throughput: one item at a time; busy drops the cycle after out_valid.
// cfg_we writes lowest priority (cfg_wdata); the user must assert it only while
// the block is idle, since the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties both queues, clears the current task
// and sets lowest priority to 8; queue RAM contents are not cleared.
module cooperative_task_scheduler_queues_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_req_type,
  input  logic [ctsq_pkg::TASK_ID_BITS-1:0]    in_task_id,
  input  logic signed [4:0]                    in_priority_req,
  input  logic [ctsq_pkg::TICK_BITS-1:0]       in_amount,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [ctsq_pkg::TASK_ID_BITS-1:0]    out_task_id,
  output logic [ctsq_pkg::EXP_W-1:0]           out_expired_count,
  input  logic                                 cfg_we,
  input  logic [ctsq_pkg::PRIO_W-1:0]          cfg_wdata
);

  localparam int TW = ctsq_pkg::TASK_ID_BITS;
  localparam int PW = ctsq_pkg::PRIO_W;
  localparam int KW = ctsq_pkg::TICK_BITS;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_RSTART  = 15'b000000000000010,
    S_RCHK    = 15'b000000000000100,
    S_RCMP    = 15'b000000000001000,
    S_DGOT    = 15'b000000000010000,
    S_DRD     = 15'b000000000100000,
    S_DWR     = 15'b000000001000000,
    S_TCHK    = 15'b000000010000000,
    S_TEVAL   = 15'b000000100000000,
    S_CRD     = 15'b000001000000000,
    S_CWR     = 15'b000010000000000,
    S_DISTART = 15'b000100000000000,
    S_DICHK   = 15'b001000000000000,
    S_DICMP   = 15'b010000000000000,
    S_FIN     = 15'b100000000000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [PW-1:0]                 lowest_r;
  logic [ctsq_pkg::RC_W-1:0]     rcount_r, rcount_nxt, ri_r, ri_nxt;
  logic [ctsq_pkg::DC_W-1:0]     dcount_r, dcount_nxt, dj_r, dj_nxt, tj_r, tj_nxt;
  logic [TW-1:0]                 cur_task_r, cur_task_nxt, ins_task_r, ins_task_nxt;
  logic [PW-1:0]                 cur_prio_r, cur_prio_nxt, ins_prio_r, ins_prio_nxt;
  logic [KW-1:0]                 amt_r, amt_nxt;
  logic                          tick_r, tick_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic [TW-1:0]                 oid_r, oid_nxt;
  logic [ctsq_pkg::EXP_W-1:0]    exp_r, exp_nxt;

  logic                          rq_we, dq_we;
  logic [ctsq_pkg::RA_W-1:0]     rq_waddr, rq_raddr;
  logic [ctsq_pkg::DA_W-1:0]     dq_waddr, dq_raddr;
  logic [ctsq_pkg::READY_W-1:0]  rq_wdata, rq_rdata;
  logic [ctsq_pkg::DELAY_W-1:0]  dq_wdata, dq_rdata;

  logic [TW-1:0]                 r_task, d_task;
  logic [PW-1:0]                 r_prio, clamp_prio;
  logic [KW-1:0]                 d_left;
  logic [ctsq_pkg::RC_W-1:0]     ri_m1;
  logic [ctsq_pkg::DC_W-1:0]     dj_m1, dj_off;

  assign r_task = rq_rdata[ctsq_pkg::READY_W-1:PW];
  assign r_prio = rq_rdata[PW-1:0];
  assign d_task = dq_rdata[ctsq_pkg::DELAY_W-1:KW];
  assign d_left = dq_rdata[KW-1:0];
  assign ri_m1  = ri_r - 1'b1;
  assign dj_m1  = dj_r - 1'b1;
  assign dj_off = dj_r - tj_r;

  always_comb begin
    if (in_priority_req[4]) begin
      clamp_prio = '0;
    end else if (in_priority_req[3:0] > lowest_r) begin
      clamp_prio = lowest_r;
    end else begin
      clamp_prio = in_priority_req[3:0];
    end
  end

  ctsq_ram #(.WIDTH(ctsq_pkg::READY_W), .DEPTH(ctsq_pkg::READY_DEPTH)) u_ready_ram (
    .clk   (clk),
    .we    (rq_we),
    .waddr (rq_waddr),
    .wdata (rq_wdata),
    .raddr (rq_raddr),
    .rdata (rq_rdata)
  );

  ctsq_ram #(.WIDTH(ctsq_pkg::DELAY_W), .DEPTH(ctsq_pkg::DELAY_DEPTH)) u_delay_ram (
    .clk   (clk),
    .we    (dq_we),
    .waddr (dq_waddr),
    .wdata (dq_wdata),
    .raddr (dq_raddr),
    .rdata (dq_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    rcount_nxt   = rcount_r;
    dcount_nxt   = dcount_r;
    ri_nxt       = ri_r;
    dj_nxt       = dj_r;
    tj_nxt       = tj_r;
    cur_task_nxt = cur_task_r;
    cur_prio_nxt = cur_prio_r;
    ins_task_nxt = ins_task_r;
    ins_prio_nxt = ins_prio_r;
    amt_nxt      = amt_r;
    tick_nxt     = tick_r;
    status_nxt   = status_r;
    oid_nxt      = oid_r;
    exp_nxt      = exp_r;
    rq_we        = 1'b0;
    rq_waddr     = ri_r[ctsq_pkg::RA_W-1:0];
    rq_wdata     = {ins_task_r, ins_prio_r};
    rq_raddr     = ri_m1[ctsq_pkg::RA_W-1:0];
    dq_we        = 1'b0;
    dq_waddr     = dj_r[ctsq_pkg::DA_W-1:0];
    dq_wdata     = {ins_task_r, amt_r};
    dq_raddr     = dj_m1[ctsq_pkg::DA_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          amt_nxt    = in_amount;
          status_nxt = ctsq_pkg::ST_DONE;
          oid_nxt    = '0;
          exp_nxt    = '0;
          tick_nxt   = 1'b0;
          case (in_req_type)
            ctsq_pkg::REQ_ADD: begin
              ins_task_nxt = in_task_id;
              ins_prio_nxt = clamp_prio;
              state_nxt    = S_RSTART;
            end
            ctsq_pkg::REQ_DISPATCH: begin
              if (rcount_r == '0) begin
                status_nxt = ctsq_pkg::ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                rq_raddr  = '0;
                state_nxt = S_DGOT;
              end
            end
            ctsq_pkg::REQ_TICK: begin
              tick_nxt  = 1'b1;
              tj_nxt    = '0;
              state_nxt = S_TCHK;
            end
            default: begin
              ins_task_nxt = cur_task_r;
              ins_prio_nxt = cur_prio_r;
              state_nxt    = (in_amount == '0) ? S_RSTART : S_DISTART;
            end
          endcase
        end
      end
      S_RSTART: begin
        if (rcount_r == ctsq_pkg::RC_W'(ctsq_pkg::READY_DEPTH)) begin
          status_nxt = ctsq_pkg::ST_DROPPED;
          state_nxt  = tick_r ? S_TCHK : S_FIN;
        end else begin
          ri_nxt    = rcount_r;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (ri_r == '0) begin
          rq_we      = 1'b1;
          rcount_nxt = rcount_r + 1'b1;
          if (tick_r) begin
            if (exp_r != '1) exp_nxt = exp_r + 1'b1;
            state_nxt = S_TCHK;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_RCMP;
        end
      end
      S_RCMP: begin
        rq_we = 1'b1;
        if (r_prio > ins_prio_r) begin
          rq_wdata  = rq_rdata;
          ri_nxt    = ri_m1;
          state_nxt = S_RCHK;
        end else begin
          rcount_nxt = rcount_r + 1'b1;
          if (tick_r) begin
            if (exp_r != '1) exp_nxt = exp_r + 1'b1;
            state_nxt = S_TCHK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DGOT: begin
        cur_task_nxt = r_task;
        cur_prio_nxt = r_prio;
        oid_nxt      = r_task;
        status_nxt   = ctsq_pkg::ST_DISPATCHED;
        ri_nxt       = ctsq_pkg::RC_W'(1);
        state_nxt    = S_DRD;
      end
      S_DRD: begin
        if (ri_r < rcount_r) begin
          rq_raddr  = ri_r[ctsq_pkg::RA_W-1:0];
          state_nxt = S_DWR;
        end else begin
          rcount_nxt = rcount_r - 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_DWR: begin
        rq_we     = 1'b1;
        rq_waddr  = ri_m1[ctsq_pkg::RA_W-1:0];
        rq_wdata  = rq_rdata;
        ri_nxt    = ri_r + 1'b1;
        state_nxt = S_DRD;
      end
      S_TCHK: begin
        if (tj_r < dcount_r) begin
          dq_raddr  = tj_r[ctsq_pkg::DA_W-1:0];
          state_nxt = S_TEVAL;
        end else begin
          dj_nxt    = tj_r;
          state_nxt = S_CRD;
        end
      end
      S_TEVAL: begin
        if (d_left <= amt_r) begin
          ins_task_nxt = d_task;
          ins_prio_nxt = '0;
          tj_nxt       = tj_r + 1'b1;
          state_nxt    = S_RSTART;
        end else begin
          dj_nxt    = tj_r;
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        if (dj_r < dcount_r) begin
          dq_raddr  = dj_r[ctsq_pkg::DA_W-1:0];
          state_nxt = S_CWR;
        end else begin
          dcount_nxt = dcount_r - tj_r;
          state_nxt  = S_FIN;
        end
      end
      S_CWR: begin
        dq_we     = 1'b1;
        dq_waddr  = dj_off[ctsq_pkg::DA_W-1:0];
        dq_wdata  = {d_task, d_left - amt_r};
        dj_nxt    = dj_r + 1'b1;
        state_nxt = S_CRD;
      end
      S_DISTART: begin
        if (dcount_r == ctsq_pkg::DC_W'(ctsq_pkg::DELAY_DEPTH)) begin
          status_nxt = ctsq_pkg::ST_DROPPED;
          state_nxt  = S_FIN;
        end else begin
          dj_nxt    = dcount_r;
          state_nxt = S_DICHK;
        end
      end
      S_DICHK: begin
        if (dj_r == '0) begin
          dq_we      = 1'b1;
          dcount_nxt = dcount_r + 1'b1;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_DICMP;
        end
      end
      S_DICMP: begin
        dq_we = 1'b1;
        if (d_left > amt_r) begin
          dq_wdata  = dq_rdata;
          dj_nxt    = dj_m1;
          state_nxt = S_DICHK;
        end else begin
          dcount_nxt = dcount_r + 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      lowest_r   <= ctsq_pkg::LOWEST_RESET;
      rcount_r   <= '0;
      dcount_r   <= '0;
      cur_task_r <= '0;
      cur_prio_r <= '0;
      tick_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rcount_r   <= rcount_nxt;
      dcount_r   <= dcount_nxt;
      cur_task_r <= cur_task_nxt;
      cur_prio_r <= cur_prio_nxt;
      tick_r     <= tick_nxt;
      if (cfg_we) begin
        lowest_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ri_r       <= ri_nxt;
    dj_r       <= dj_nxt;
    tj_r       <= tj_nxt;
    ins_task_r <= ins_task_nxt;
    ins_prio_r <= ins_prio_nxt;
    amt_r      <= amt_nxt;
    status_r   <= status_nxt;
    oid_r      <= oid_nxt;
    exp_r      <= exp_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_FIN);
  assign out_status        = status_r;
  assign out_task_id       = oid_r;
  assign out_expired_count = exp_r;

endmodule

/* rtl/core/ctsq_ram.sv */
module ctsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ctsq_checker.sv */
module ctsq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [1:0]                        out_status,
  input logic [ctsq_pkg::TASK_ID_BITS-1:0] out_task_id,
  input logic [ctsq_pkg::EXP_W-1:0]        out_expired_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ctsq_pkg::ST_DISPATCHED |-> out_task_id == '0)
    else $error("task id set without dispatch");

  a_exp_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ctsq_pkg::ST_DISPATCHED ||
                  out_status == ctsq_pkg::ST_EMPTY) |-> out_expired_count == '0)
    else $error("expired count on a dispatch result");

endmodule

bind cooperative_task_scheduler_queues_core ctsq_checker u_ctsq_checker (.*);

/* tb/cooperative_task_scheduler_queues_core_test.sv */
module cooperative_task_scheduler_queues_core_test;

  typedef struct {
    ctsq_pkg::req_t req;
    logic [7:0]     tid;
    logic [4:0]     preq;
    logic [15:0]    amt;
  } sched_req_t;

  typedef struct {
    ctsq_pkg::status_t st;
    logic [7:0]        tid;
    logic [4:0]        exp_n;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [ctsq_pkg::TASK_ID_BITS-1:0] in_task_id = '0;
  logic signed [4:0] in_priority_req = '0;
  logic [ctsq_pkg::TICK_BITS-1:0] in_amount = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [ctsq_pkg::TASK_ID_BITS-1:0] out_task_id;
  logic [ctsq_pkg::EXP_W-1:0] out_expired_count;
  logic cfg_we = 1'b0;
  logic [ctsq_pkg::PRIO_W-1:0] cfg_wdata = '0;

  cooperative_task_scheduler_queues_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_task_id(in_task_id),
    .in_priority_req(in_priority_req), .in_amount(in_amount),
    .out_valid(out_valid), .out_status(out_status), .out_task_id(out_task_id),
    .out_expired_count(out_expired_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  sched_req_t drv_req;
  sched_req_t mon_req;
  sched_rsp_t mon_exp;
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  logic accepted_q = 1'b0;

  logic [3:0]  lowest;
  logic [7:0]  rdy_task[$];
  logic [3:0]  rdy_prio[$];
  logic [7:0]  dly_task[$];
  logic [15:0] dly_left[$];
  logic [7:0]  cur_task;
  logic [3:0]  cur_prio;

  logic [3:0] cfg_vals[5] = '{4'd15, 4'd0, 4'd8, 4'd3, 4'd15};

  function automatic bit ready_push(logic [7:0] t, logic [3:0] p);
    int pos;
    pos = 0;
    if (rdy_task.size() >= ctsq_pkg::READY_DEPTH) return 1'b0;
    while (pos < rdy_task.size() && rdy_prio[pos] <= p) pos++;
    rdy_task.insert(pos, t);
    rdy_prio.insert(pos, p);
    return 1'b1;
  endfunction

  function automatic sched_rsp_t schedule(sched_req_t r);
    sched_rsp_t o;
    int pos, n;
    logic [3:0] p;
    o.st = ctsq_pkg::ST_DONE;
    o.tid = '0;
    o.exp_n = '0;
    case (r.req)
      ctsq_pkg::REQ_ADD: begin
        if (r.preq[4]) p = 4'd0;
        else if (r.preq[3:0] > lowest) p = lowest;
        else p = r.preq[3:0];
        if (!ready_push(r.tid, p)) o.st = ctsq_pkg::ST_DROPPED;
      end
      ctsq_pkg::REQ_DISPATCH: begin
        if (rdy_task.size() == 0) o.st = ctsq_pkg::ST_EMPTY;
        else begin
          cur_task = rdy_task.pop_front();
          cur_prio = rdy_prio.pop_front();
          o.tid = cur_task;
          o.st = ctsq_pkg::ST_DISPATCHED;
        end
      end
      ctsq_pkg::REQ_TICK: begin
        n = 0;
        while (n < dly_task.size() && dly_left[n] <= r.amt) n++;
        for (int i = 0; i < n; i++) begin
          if (ready_push(dly_task[0], 4'd0)) begin
            if (o.exp_n < 5'd31) o.exp_n++;
          end else o.st = ctsq_pkg::ST_DROPPED;
          void'(dly_task.pop_front());
          void'(dly_left.pop_front());
        end
        foreach (dly_left[i]) dly_left[i] = dly_left[i] - r.amt;
      end
      default: begin
        if (r.amt == 0) begin
          if (!ready_push(cur_task, cur_prio)) o.st = ctsq_pkg::ST_DROPPED;
        end else if (dly_task.size() >= ctsq_pkg::DELAY_DEPTH) o.st = ctsq_pkg::ST_DROPPED;
        else begin
          pos = 0;
          while (pos < dly_task.size() && dly_left[pos] <= r.amt) pos++;
          dly_task.insert(pos, cur_task);
          dly_left.insert(pos, r.amt);
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    accepted_q <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      mon_req.req = ctsq_pkg::req_t'(in_req_type);
      mon_req.tid = in_task_id;
      mon_req.preq = in_priority_req;
      mon_req.amt = in_amount;
      expected_rsps.push_back(schedule(mon_req));
    end
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result: exp none got st=%0d id=%0d exp=%0d",
                   out_status, out_task_id, out_expired_count);
      end else begin
        mon_exp = expected_rsps.pop_front();
        if (out_status !== mon_exp.st || out_task_id !== mon_exp.tid ||
            out_expired_count !== mon_exp.exp_n) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%0d exp=%0d got st=%0d id=%0d exp=%0d",
                     mon_exp.st, mon_exp.tid, mon_exp.exp_n,
                     out_status, out_task_id, out_expired_count);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || accepted_q) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else begin
        drv_req = pending_reqs.pop_front();
        start <= 1'b1;
        in_req_type <= drv_req.req;
        in_task_id <= drv_req.tid;
        in_priority_req <= drv_req.preq;
        in_amount <= drv_req.amt;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  task automatic add_req(ctsq_pkg::req_t q, logic [7:0] t, logic [4:0] p, logic [15:0] a);
    sched_req_t r;
    r.req = q;
    r.tid = t;
    r.preq = p;
    r.amt = a;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0 || busy)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_lowest(logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lowest = v;
  endtask

  task automatic random_phase(int n);
    int k;
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: a = 16'($urandom_range(0, 3));
        1: a = 16'($urandom_range(0, 40));
        2: a = 16'($urandom);
        default: a = 16'($urandom_range(0, 15));
      endcase
      if (k < 3) add_req(ctsq_pkg::REQ_ADD, 8'($urandom), 5'($urandom), a);
      else if (k < 5) add_req(ctsq_pkg::REQ_DISPATCH, 8'($urandom), 5'($urandom), a);
      else if (k < 7) add_req(ctsq_pkg::REQ_TICK, 8'($urandom), 5'($urandom), a);
      else add_req(ctsq_pkg::REQ_RERUN, 8'($urandom), 5'($urandom), (k == 7) ? 16'd0 : a);
    end
  endtask

  initial begin
    lowest = ctsq_pkg::LOWEST_RESET;
    cur_task = '0;
    cur_prio = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_req(ctsq_pkg::REQ_RERUN, 8'd0, 5'd0, 16'd0);
    add_req(ctsq_pkg::REQ_DISPATCH, 8'd0, 5'd0, 16'd0);
    add_req(ctsq_pkg::REQ_DISPATCH, 8'd0, 5'd0, 16'd0);
    add_req(ctsq_pkg::REQ_ADD, 8'hFF, 5'b10000, 16'hFFFF);
    add_req(ctsq_pkg::REQ_ADD, 8'h00, 5'b01111, 16'd0);
    add_req(ctsq_pkg::REQ_ADD, 8'h5A, 5'd8, 16'd0);
    add_req(ctsq_pkg::REQ_ADD, 8'hA5, 5'd3, 16'd0);
    add_req(ctsq_pkg::REQ_DISPATCH, 8'd0, 5'd0, 16'd0);
    add_req(ctsq_pkg::REQ_RERUN, 8'd0, 5'd0, 16'd5);
    add_req(ctsq_pkg::REQ_DISPATCH, 8'd0, 5'd0, 16'd0);
    add_req(ctsq_pkg::REQ_RERUN, 8'd0, 5'd0, 16'hFFFF);
    add_req(ctsq_pkg::REQ_TICK, 8'd0, 5'd0, 16'd0);
    add_req(ctsq_pkg::REQ_TICK, 8'd0, 5'd0, 16'd7);
    add_req(ctsq_pkg::REQ_TICK, 8'd0, 5'd0, 16'hFFFF);
    for (int i = 0; i < 18; i++) add_req(ctsq_pkg::REQ_ADD, 8'(i * 13), 5'($urandom), 16'd0);
    for (int i = 0; i < 18; i++)
      add_req(ctsq_pkg::REQ_RERUN, 8'd0, 5'd0, 16'($urandom_range(1, 3)));
    add_req(ctsq_pkg::REQ_TICK, 8'd0, 5'd0, 16'd3);
    drain();

    foreach (cfg_vals[j]) begin
      set_lowest(cfg_vals[j]);
      random_phase(310);
      drain();
    end

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 4000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/core/ctsq_pkg.sv
rtl/core/ctsq_ram.sv
rtl/core/cooperative_task_scheduler_queues_core.sv
rtl/core/ctsq_checker.sv
tb/cooperative_task_scheduler_queues_core_test.sv
